[rtl/average_scale_f16_f32_unit_assert.svh]
// Assertion macros for the averaging scale unit.
// Used by the top level only; no other dependencies.
`ifndef AVERAGE_SCALE_F16_F32_UNIT_ASSERT_SVH
`define AVERAGE_SCALE_F16_F32_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/avs_pkg.sv]
// Shared constants, types and helper functions for the averaging scale unit.
// No dependencies.
package avs_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGING_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BITS   = 2'd2;

  localparam logic [31:0] SCALE_RST   = 32'h3f80_0000;
  localparam logic [31:0] INF32       = 32'h7f80_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
  localparam logic [31:0] QUIET32     = 32'h0040_0000;
  localparam logic [14:0] QNAN16      = 15'h7e00;
  localparam logic [14:0] INF16       = 15'h7c00;

  typedef struct packed {
    logic [23:0]        m;
    logic signed [9:0]  e;
  } unp_t;

  // Exact binary16 -> binary32 widening, subnormals and NaN payload kept.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [3:0]  msb;
    logic [3:0]  n;
    logic [7:0]  e;
    logic [10:0] sm;
    logic [31:0] r;
    msb = '0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) msb = 4'(i);
    end
    n  = 4'd10 - msb;
    e  = 8'd113 - {4'd0, n};
    sm = {1'b0, h[9:0]} << n;
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) r = {h[15], 31'd0};
      else                 r = {h[15], e, sm[9:0], 13'd0};
    end else if (h[14:10] == 5'h1f) begin
      r = {h[15], 8'hff, h[9:0], 13'd0};
    end else begin
      r = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
    end
    return r;
  endfunction

  // Finite nonzero magnitude -> 24-bit mantissa with hidden bit, unbiased exponent.
  function automatic unp_t unpack(input logic [30:0] x);
    unp_t       u;
    logic [4:0] msb;
    logic [4:0] n;
    msb = '0;
    for (int i = 0; i < 23; i++) begin
      if (x[i]) msb = 5'(i);
    end
    n = 5'd23 - msb;
    if (x[30:23] == 8'd0) begin
      u.m = {1'b0, x[22:0]} << n;
      u.e = -10'sd126 - $signed({5'd0, n});
    end else begin
      u.m = {1'b1, x[22:0]};
      u.e = $signed({2'd0, x[30:23]}) - 10'sd127;
    end
    return u;
  endfunction

endpackage

[rtl/avs_narrow.sv]
// binary32 -> binary16 narrowing with round-to-nearest-even.
// Depends on avs_pkg.
module avs_narrow (
  input  logic [31:0] bits,
  output logic [15:0] half
);

  logic               sign;
  logic [7:0]         ex;
  logic [22:0]        man;
  logic signed [9:0]  he;
  logic signed [9:0]  he1;
  logic [23:0]        mm;
  logic [4:0]         sh;
  logic [23:0]        mq;
  logic [24:0]        r;
  logic [24:0]        rs;
  logic [23:0]        m2;

  assign sign = bits[31];
  assign ex   = bits[30:23];
  assign man  = bits[22:0];
  assign he   = $signed({2'd0, ex}) - 10'sd112;
  assign he1  = he + 10'sd1;
  assign mm   = {1'b1, man};
  assign sh   = 5'(10'sd14 - he);
  assign mq   = mm >> sh;
  assign r    = {1'b0, mm} + ((25'd1 << (sh - 5'd1)) - 25'd1) + {24'd0, mq[0]};
  assign rs   = r >> sh;
  assign m2   = {1'b0, man} + 24'h000fff + {23'd0, man[13]};

  always_comb begin
    if (ex == 8'hff) begin
      half = {sign, (man != 23'd0) ? avs_pkg::QNAN16 : avs_pkg::INF16};
    end else if (he >= 10'sd31) begin
      half = {sign, avs_pkg::INF16};
    end else if (he <= 10'sd0) begin
      if (he < -10'sd10) half = {sign, 15'd0};
      else               half = {sign, rs[14:0]};
    end else if (m2[23]) begin
      if (he1 >= 10'sd31) half = {sign, avs_pkg::INF16};
      else                half = {sign, he1[4:0], 10'd0};
    end else begin
      half = {sign, he[4:0], m2[22:13]};
    end
  end

endmodule

[rtl/average_scale_f16_f32_unit.sv]
// Averaging scale unit: multiplies each streamed element by a binary32
// reciprocal of the world size. Depends on avs_pkg, avs_narrow and the assert header.
//
// Takes one element per clock and delivers one result per clock while out_stall
// is low; out_valid rises once the element has moved through the register
// stages in turn. Four register stages:
// (1) binary16 widening, special-case screening and operand unpacking,
// (2) the 24x24 mantissa multiplier, (3) product normalization and
// round-to-nearest-even into binary32, (4) optional binary16 narrowing into
// the output register. Each stage holds its own valid bit and loads whenever
// it is empty or its successor loads, so out_stall only freezes the stages
// that actually hold data and bubbles close up. Configuration (elem_format,
// averaging_on, scale_bits) is sampled as an element enters and travels with it.
// With averaging off an element passes through unchanged (binary16: upper
// half zero).
module average_scale_f16_f32_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [avs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_element_bits,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_result_bits,
  output logic                          out_last_out
);

`include "average_scale_f16_f32_unit_assert.svh"

  // ---------------- configuration registers ----------------
  logic        fmt_r, avg_r;
  logic [31:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      avg_r   <= 1'b0;
      scale_r <= avs_pkg::SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avs_pkg::CFG_ELEM_FORMAT:  fmt_r   <= cfg_wdata[0];
        avs_pkg::CFG_AVERAGING_ON: avg_r   <= cfg_wdata[0];
        avs_pkg::CFG_SCALE_BITS:   scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage load control ----------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4      = !v4_r || !out_stall;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: widen, screen, unpack ----------------
  logic [31:0]   x_a;
  logic [31:0]   pass_a;
  logic [30:0]   aa, ba;
  logic          sgn_a;
  logic          spec_nxt;
  logic [31:0]   spec_val_nxt;
  avs_pkg::unp_t ua, ub;

  assign pass_a = fmt_r ? {16'd0, in_element_bits[15:0]} : in_element_bits;
  assign x_a    = fmt_r ? avs_pkg::widen_half(in_element_bits[15:0]) : in_element_bits;
  assign aa     = x_a[30:0];
  assign ba     = scale_r[30:0];
  assign sgn_a  = x_a[31] ^ scale_r[31];
  assign ua     = avs_pkg::unpack(aa);
  assign ub     = avs_pkg::unpack(ba);

  always_comb begin
    spec_nxt     = 1'b1;
    spec_val_nxt = pass_a;
    if (!avg_r) begin
      spec_val_nxt = pass_a;
    end else if ({1'b0, aa} > avs_pkg::INF32) begin
      spec_val_nxt = x_a | avs_pkg::QUIET32;          // NaN element wins
    end else if ({1'b0, ba} > avs_pkg::INF32) begin
      spec_val_nxt = scale_r | avs_pkg::QUIET32;
    end else if ({1'b0, aa} == avs_pkg::INF32 || {1'b0, ba} == avs_pkg::INF32) begin
      if (aa == 31'd0 || ba == 31'd0) spec_val_nxt = avs_pkg::DEFAULT_NAN;
      else                            spec_val_nxt = {sgn_a, avs_pkg::INF32[30:0]};
    end else if (aa == 31'd0 || ba == 31'd0) begin
      spec_val_nxt = {sgn_a, 31'd0};
    end else begin
      spec_nxt = 1'b0;
    end
  end

  logic              s1_fmt_r, s1_avg_r, s1_last_r, s1_spec_r, s1_sgn_r;
  logic [31:0]       s1_val_r;
  logic [23:0]       s1_ma_r, s1_mb_r;
  logic signed [9:0] s1_ea_r, s1_eb_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_fmt_r  <= fmt_r;
      s1_avg_r  <= avg_r;
      s1_last_r <= in_last_in;
      s1_spec_r <= spec_nxt;
      s1_val_r  <= spec_val_nxt;
      s1_sgn_r  <= sgn_a;
      s1_ma_r   <= ua.m;
      s1_mb_r   <= ub.m;
      s1_ea_r   <= ua.e;
      s1_eb_r   <= ub.e;
    end
  end

  // ---------------- stage 2: mantissa multiply ----------------
  logic               s2_fmt_r, s2_avg_r, s2_last_r, s2_spec_r, s2_sgn_r;
  logic [31:0]        s2_val_r;
  logic [47:0]        s2_p_r;
  logic signed [10:0] s2_be_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_fmt_r  <= s1_fmt_r;
      s2_avg_r  <= s1_avg_r;
      s2_last_r <= s1_last_r;
      s2_spec_r <= s1_spec_r;
      s2_sgn_r  <= s1_sgn_r;
      s2_val_r  <= s1_val_r;
      s2_p_r    <= s1_ma_r * s1_mb_r;
      s2_be_r   <= 11'(s1_ea_r) + 11'(s1_eb_r) + 11'sd127;
    end
  end

  // ---------------- stage 3: normalize and round ----------------
  logic [47:0]        pn;
  logic signed [10:0] be;
  logic [5:0]         sh;
  logic [31:0]        base;
  logic [63:0]        pw, q, rem, half, mask;
  logic [31:0]        field;
  logic [31:0]        mul_res;

  assign pn   = s2_p_r[47] ? s2_p_r : {s2_p_r[46:0], 1'b0};
  assign be   = s2_p_r[47] ? s2_be_r + 11'sd1 : s2_be_r;
  assign sh   = (be >= 11'sd1) ? 6'd24 : 6'(11'sd25 - be);
  assign base = (be >= 11'sd1) ? {be[8:0] - 9'd1, 23'd0} : 32'd0;
  assign pw   = {16'd0, pn};
  assign q    = pw >> sh;
  assign mask = (64'd1 << sh) - 64'd1;
  assign rem  = pw & mask;
  assign half = 64'd1 << (sh - 6'd1);

  always_comb begin
    field = base + q[31:0];
    if (rem > half || (rem == half && q[0])) field = field + 32'd1;
    if (field >= avs_pkg::INF32) field = avs_pkg::INF32;
    if (be >= 11'sd255)      mul_res = {s2_sgn_r, avs_pkg::INF32[30:0]};
    else if (be < -11'sd25)  mul_res = {s2_sgn_r, 31'd0};
    else                     mul_res = {s2_sgn_r, field[30:0]};
  end

  logic        s3_narrow_r, s3_last_r;
  logic [31:0] s3_val_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_narrow_r <= s2_fmt_r && s2_avg_r;
      s3_last_r   <= s2_last_r;
      s3_val_r    <= s2_spec_r ? s2_val_r : mul_res;
    end
  end

  // ---------------- stage 4: narrowing, output register ----------------
  logic [15:0] half16;

  avs_narrow u_narrow (
    .bits (s3_val_r),
    .half (half16)
  );

  logic [31:0] res_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      res_r  <= s3_narrow_r ? {16'd0, half16} : s3_val_r;
      last_r <= s3_last_r;
    end
  end

  assign out_valid       = v4_r;
  assign out_result_bits = res_r;
  assign out_last_out    = last_r;

  // ---------------- assertions ----------------
  `AVS_ASSERT_NEXT(a_in_reaches_s1, clk, rst_n, in_valid && !in_stall, v1_r,
    "accepted transaction did not enter stage 1")
  `AVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_result_bits) && $stable(out_last_out),
    "stalled output transaction changed")
  `AVS_ASSERT_NEXT(a_narrow_upper_zero, clk, rst_n, v3_r && ld4 && s3_narrow_r,
    out_result_bits[31:16] == 16'd0, "binary16 result has nonzero upper half")
  `AVS_ASSERT_SAME(a_full_stall, clk, rst_n, in_stall, v1_r && v2_r && v3_r && v4_r,
    "input stalled while pipeline has a free stage")

endmodule
